// File: rtl/elastoplastic_contact_normal_force_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elastoplastic contact normal force core
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ELASTOPLASTIC_CONTACT_NORMAL_FORCE_CORE_MACROS_SVH
`define ELASTOPLASTIC_CONTACT_NORMAL_FORCE_CORE_MACROS_SVH

// Same-cycle implication.
`define ECNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ECNF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ecnf_pkg.sv
// ----------------------------------------------------------------------------
// ecnf_pkg
// Types, constants and saturating helpers of the contact normal force core.
// ----------------------------------------------------------------------------
package ecnf_pkg;

  localparam int unsigned VW   = 48;          // signed value width
  localparam int unsigned FB   = 24;          // fraction bits
  localparam int unsigned UW   = VW - 1;      // unsigned value width
  localparam int unsigned PW   = 2 * VW;      // full product width
  localparam int unsigned TW   = FB + 7;      // clamped growth term, holds 100.0
  localparam int unsigned INCW = UW + TW - FB; // stiffness increment width
  localparam int unsigned CIW  = 3;           // register index width
  localparam int unsigned CW   = $clog2(VW);  // iteration counter width

  localparam logic signed [VW-1:0] SMAX  = {1'b0, {UW{1'b1}}};
  localparam logic signed [VW-1:0] SMIN  = {1'b1, {UW{1'b0}}};
  localparam logic [UW-1:0]        UMAX  = {UW{1'b1}};
  localparam logic [UW-1:0]        ONE_Q = UW'(1) << FB;

  typedef enum logic [2:0] {
    REG_SEPARATED = 3'd0,
    REG_COHESIVE  = 3'd1,
    REG_LOADING   = 3'd2,
    REG_UNLOADING = 3'd3,
    REG_ELASTIC   = 3'd4
  } regime_e;

  typedef enum logic [CIW-1:0] {
    CFG_ELASTIC_K   = 3'd0,
    CFG_CRIT_OVLP   = 3'd1,
    CFG_LATCH_SLOPE = 3'd2,
    CFG_VAR_UNLOAD  = 3'd3,
    CFG_FIXED_K     = 3'd4,
    CFG_COH_EN      = 3'd5,
    CFG_PULL_OFF    = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLASSIFY,
    OP_K2_START,
    OP_K2_T,
    OP_K2_FIN,
    OP_COH_DIV,
    OP_COH_EDGE,
    OP_UO_MUL,
    OP_UO_DIV,
    OP_UO_SET,
    OP_F_MUL,
    OP_F_SET,
    OP_E_MUL,
    OP_E_DIV,
    OP_E_SET,
    OP_PUSH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_K2_START,
    ST_K2_W1,
    ST_K2_W2,
    ST_DISPATCH,
    ST_COH_W,
    ST_COH_CHK,
    ST_UO_MW,
    ST_UO_DW,
    ST_F_START,
    ST_F_W,
    ST_E_START,
    ST_E_MW,
    ST_E_DW,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic signed [VW-1:0] overlap;
    logic                 apply_forces;
  } in_item_t;

  typedef struct packed {
    logic [UW-1:0]        stiffness;
    logic signed [VW-1:0] force_increment;
    logic [UW-1:0]        energy_increment;
    regime_e              regime;
  } out_item_t;

  typedef struct packed {
    logic    mul_done;
    logic    div_done;
    logic    need_k2;
    logic    k2_direct;
    logic    in_range;
    logic    k_ne_el;
    logic    apply;
    regime_e regime;
  } dp_sts_t;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? SMIN : SMAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_neg(input logic signed [VW-1:0] a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
    logic [VW-1:0] ua;
    ua = a;
    return ua[VW-1] ? (~ua + VW'(1)) : ua;
  endfunction

  // Magnitude plus sign back to a saturated signed value.
  function automatic logic signed [VW-1:0] sat_from(input logic [PW-1:0] m,
                                                    input logic neg);
    logic big;
    big = |m[PW-1:UW];
    if (neg) begin
      return big ? SMIN : -$signed(m[VW-1:0]);
    end
    return big ? SMAX : $signed(m[VW-1:0]);
  endfunction

endpackage

// File: rtl/ecnf_mul.sv
// ----------------------------------------------------------------------------
// ecnf_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ecnf_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ecnf_pkg::VW-1:0] a_i,
  input  logic [ecnf_pkg::VW-1:0] b_i,
  output logic [ecnf_pkg::PW-1:0] prod_o,
  output logic                    done_o
);
  import ecnf_pkg::*;

  logic [PW-1:0] acc_q, acc_d;
  logic [VW-1:0] a_q, a_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   sum;

  always_comb begin
    sum    = {1'b0, acc_q[PW-1:VW]} + (acc_q[0] ? {1'b0, a_q} : '0);
    acc_d  = acc_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = {{VW{1'b0}}, b_i};
      a_d    = a_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {sum, acc_q[VW-1:1]};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(VW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// File: rtl/ecnf_div.sv
// ----------------------------------------------------------------------------
// ecnf_div
// Restoring divider with an up-front overflow check; the quotient saturates
// to one past the largest signed magnitude.
// ----------------------------------------------------------------------------
module ecnf_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ecnf_pkg::PW-1:0] n_i,
  input  logic [ecnf_pkg::VW-1:0] d_i,
  output logic [ecnf_pkg::VW-1:0] q_o,
  output logic                    done_o
);
  import ecnf_pkg::*;

  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] num_q, num_d;
  logic [VW-1:0] quo_q, quo_d;
  logic [VW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   r2;
  logic          ge;
  logic          ovf;
  logic          nul;

  always_comb begin
    r2     = {rem_q, num_q[VW-1]};
    ge     = r2 >= {1'b0, den_q};
    ovf    = (d_i == '0) ? (n_i != '0) : (n_i >= {1'b0, d_i, {(VW - 1){1'b0}}});
    nul    = (d_i == '0) && (n_i == '0);
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      if (ovf || nul) begin
        // Finish at once: saturate, or zero over zero.
        quo_d  = ovf ? {1'b1, {UW{1'b0}}} : '0;
        done_d = 1'b1;
      end else begin
        rem_d  = n_i[PW-1:VW];
        num_d  = n_i[VW-1:0];
        den_d  = d_i;
        quo_d  = '0;
        cnt_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? VW'(r2 - {1'b0, den_q}) : r2[VW-1:0];
      num_d = {num_q[VW-2:0], 1'b0};
      quo_d = {quo_q[VW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(VW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign q_o    = quo_q;
  assign done_o = done_q;

endmodule

// File: rtl/ecnf_dp.sv
// ----------------------------------------------------------------------------
// ecnf_dp
// Datapath: configuration registers, contact state, shared multiplier and
// divider, and the operand selection driven by the controller.
// ----------------------------------------------------------------------------
module ecnf_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ecnf_pkg::dp_op_e         op_i,
  input  logic                     cfg_we_i,
  input  logic [ecnf_pkg::CIW-1:0] cfg_idx_i,
  input  logic [ecnf_pkg::VW-1:0]  cfg_data_i,
  input  ecnf_pkg::in_item_t       in_i,
  output ecnf_pkg::dp_sts_t        sts_o,
  output ecnf_pkg::out_item_t      res_o
);
  import ecnf_pkg::*;

  // configuration
  logic [UW-1:0]        el_k_q, ac_q, slope_q, fix_k_q;
  logic                 var_q, coh_q;
  logic signed [VW-1:0] pull_q;
  // contact state
  logic signed [VW-1:0] mo_q, mo_d, uo_q, uo_d;
  // per-item working registers
  logic signed [VW-1:0] x_q, x_d, arg_q, arg_d, f_q, f_d, lim_q, lim_d;
  logic                 apply_q, apply_d, fneg_q, fneg_d;
  logic [UW-1:0]        k_q, k_d, e_q, e_d;
  regime_e              regime_q, regime_d;

  logic                 mul_start, div_start, mul_done, div_done;
  logic [VW-1:0]        mul_a, mul_b, div_d, div_q;
  logic [PW-1:0]        mul_p, div_n;

  logic signed [VW-1:0] ac_s, a_s, cls_arg, diffk, fv, coh_d;
  logic                 below, cls_need;
  regime_e              cls_regime;
  logic [TW-1:0]        t_cl;
  logic [INCW-1:0]      inc, lim100;
  logic [INCW:0]        k2sum, kmin;
  logic                 k2_direct;

  always_comb begin
    ac_s      = {1'b0, ac_q};
    a_s       = (mo_q < ac_s) ? ac_s : mo_q;
    below     = x_q < uo_q;
    k2_direct = !var_q || (arg_q <= ac_s);
    if (below) begin
      cls_regime = coh_q ? REG_COHESIVE : REG_SEPARATED;
    end else if (x_q > a_s) begin
      cls_regime = REG_LOADING;
    end else if (a_s > ac_s) begin
      cls_regime = REG_UNLOADING;
    end else begin
      cls_regime = REG_ELASTIC;
    end
    cls_arg  = (cls_regime == REG_COHESIVE) ? mo_q :
               (cls_regime == REG_LOADING) ? x_q : a_s;
    cls_need = ((cls_regime == REG_COHESIVE) && (mo_q > ac_s)) ||
               (cls_regime == REG_LOADING) || (cls_regime == REG_UNLOADING);

    // Clamp the growth term: anything past 100.0 already hits the ceiling.
    t_cl   = (|mul_p[PW-1:FB+TW]) ? '1 : mul_p[FB+TW-1:FB];
    inc    = mul_p[UW+TW-1:FB];
    lim100 = INCW'(el_k_q) * INCW'(100);
    k2sum  = {1'b0, inc} + (INCW + 1)'(el_k_q);
    kmin   = (k2sum < {1'b0, lim100}) ? k2sum : {1'b0, lim100};

    diffk = $signed({1'b0, k_q}) - $signed({1'b0, el_k_q});
    if (regime_q == REG_COHESIVE) begin
      fv = sat_add(lim_q, sat_neg(x_q));
    end else if (regime_q == REG_ELASTIC) begin
      fv = x_q;
    end else begin
      fv = sat_add(x_q, sat_neg(uo_q));
    end
    coh_d = sat_from({{VW{1'b0}}, div_q}, pull_q > 0);

    mo_d      = mo_q;
    uo_d      = uo_q;
    x_d       = x_q;
    apply_d   = apply_q;
    arg_d     = arg_q;
    f_d       = f_q;
    e_d       = e_q;
    k_d       = k_q;
    lim_d     = lim_q;
    fneg_d    = fneg_q;
    regime_d  = regime_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;

    unique case (op_i)
      OP_LOAD: begin
        x_d     = in_i.overlap;
        apply_d = in_i.apply_forces;
        f_d     = '0;
        e_d     = '0;
      end
      OP_CLASSIFY: begin
        regime_d = cls_regime;
        arg_d    = cls_arg;
        k_d      = (cls_regime == REG_SEPARATED) ? UW'(1) : el_k_q;
        if (apply_q && !below) begin
          mo_d = (cls_regime == REG_LOADING) ? x_q : a_s;
        end
      end
      OP_K2_START: begin
        if (k2_direct) begin
          k_d = var_q ? el_k_q : fix_k_q;
        end else begin
          mul_start = 1'b1;
          mul_a     = {1'b0, slope_q};
          mul_b     = VW'(arg_q - ac_s);
        end
      end
      OP_K2_T: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, el_k_q};
        mul_b     = {{(VW - TW){1'b0}}, t_cl};
      end
      OP_K2_FIN: begin
        k_d = (kmin > (INCW + 1)'(UMAX)) ? UMAX : kmin[UW-1:0];
      end
      OP_COH_DIV: begin
        div_start = 1'b1;
        div_n     = {{(VW - FB){1'b0}}, mag(pull_q), {FB{1'b0}}};
        div_d     = {1'b0, k_q};
      end
      OP_COH_EDGE: begin
        lim_d = sat_add(uo_q, sat_neg(coh_d));
      end
      OP_UO_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag(diffk);
        mul_b     = mag(x_q);
      end
      OP_UO_DIV: begin
        div_start = 1'b1;
        div_n     = mul_p;
        div_d     = {1'b0, k_q};
      end
      OP_UO_SET: begin
        uo_d = sat_from({{VW{1'b0}}, div_q}, k_q < el_k_q);
      end
      OP_F_MUL: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, k_q};
        mul_b     = mag(fv);
        fneg_d    = fv[VW-1];
      end
      OP_F_SET: begin
        f_d = sat_from({{FB{1'b0}}, mul_p[PW-1:FB]}, fneg_q);
      end
      OP_E_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag(f_q);
        mul_b     = mag(f_q);
      end
      OP_E_DIV: begin
        div_start = 1'b1;
        div_n     = mul_p;
        div_d     = {k_q, 1'b0};
      end
      OP_E_SET: begin
        if (k_q == '0) begin
          e_d = '0;
        end else begin
          e_d = (div_q > VW'(UMAX)) ? UMAX : div_q[UW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  ecnf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_p),
    .done_o  (mul_done)
  );

  ecnf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .q_o     (div_q),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_k_q  <= ONE_Q;
      ac_q    <= '0;
      slope_q <= '0;
      var_q   <= 1'b1;
      fix_k_q <= ONE_Q;
      coh_q   <= 1'b0;
      pull_q  <= '0;
      mo_q    <= '0;
      uo_q    <= '0;
    end else begin
      mo_q <= mo_d;
      uo_q <= uo_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ELASTIC_K:   el_k_q  <= cfg_data_i[UW-1:0];
          CFG_CRIT_OVLP:   ac_q    <= cfg_data_i[UW-1:0];
          CFG_LATCH_SLOPE: slope_q <= cfg_data_i[UW-1:0];
          CFG_VAR_UNLOAD:  var_q   <= cfg_data_i[0];
          CFG_FIXED_K:     fix_k_q <= cfg_data_i[UW-1:0];
          CFG_COH_EN:      coh_q   <= cfg_data_i[0];
          CFG_PULL_OFF:    pull_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    apply_q  <= apply_d;
    arg_q    <= arg_d;
    f_q      <= f_d;
    e_q      <= e_d;
    k_q      <= k_d;
    lim_q    <= lim_d;
    fneg_q   <= fneg_d;
    regime_q <= regime_d;
  end

  always_comb begin
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.need_k2   = cls_need;
    sts_o.k2_direct = k2_direct;
    sts_o.in_range  = x_q >= lim_q;
    sts_o.k_ne_el   = k_q != el_k_q;
    sts_o.apply     = apply_q;
    sts_o.regime    = regime_q;
    res_o.stiffness        = k_q;
    res_o.force_increment  = f_q;
    res_o.energy_increment = e_q;
    res_o.regime           = regime_q;
  end

endmodule

// File: rtl/ecnf_ctrl.sv
// ----------------------------------------------------------------------------
// ecnf_ctrl
// Sequencer: walks one contact update through classification, unloading
// stiffness, cohesion limit, unloaded overlap, force and energy.
// ----------------------------------------------------------------------------
module ecnf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  input  ecnf_pkg::dp_sts_t  sts_i,
  output ecnf_pkg::dp_op_e   op_o
);
  import ecnf_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_CLASSIFY;
      ST_CLASSIFY: state_d = sts_i.need_k2 ? ST_K2_START : ST_DISPATCH;
      ST_K2_START: state_d = sts_i.k2_direct ? ST_DISPATCH : ST_K2_W1;
      ST_K2_W1:    if (sts_i.mul_done) state_d = ST_K2_W2;
      ST_K2_W2:    if (sts_i.mul_done) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!sts_i.apply || (sts_i.regime == REG_SEPARATED)) begin
          state_d = ST_OUT;
        end else if (sts_i.regime == REG_COHESIVE) begin
          state_d = ST_COH_W;
        end else if ((sts_i.regime == REG_LOADING) && sts_i.k_ne_el) begin
          state_d = ST_UO_MW;
        end else begin
          state_d = ST_F_START;
        end
      end
      ST_COH_W:    if (sts_i.div_done) state_d = ST_COH_CHK;
      ST_COH_CHK:  state_d = sts_i.in_range ? ST_F_START : ST_OUT;
      ST_UO_MW:    if (sts_i.mul_done) state_d = ST_UO_DW;
      ST_UO_DW:    if (sts_i.div_done) state_d = ST_F_START;
      ST_F_START:  state_d = ST_F_W;
      ST_F_W:      if (sts_i.mul_done) state_d = ST_E_START;
      ST_E_START:  state_d = ST_E_MW;
      ST_E_MW:     if (sts_i.mul_done) state_d = ST_E_DW;
      ST_E_DW:     if (sts_i.div_done) state_d = ST_OUT;
      ST_OUT:      if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      ST_CLASSIFY: op_o = OP_CLASSIFY;
      ST_K2_START: op_o = OP_K2_START;
      ST_K2_W1:    if (sts_i.mul_done) op_o = OP_K2_T;
      ST_K2_W2:    if (sts_i.mul_done) op_o = OP_K2_FIN;
      ST_DISPATCH: begin
        if (sts_i.apply && (sts_i.regime == REG_COHESIVE)) begin
          op_o = OP_COH_DIV;
        end else if (sts_i.apply && (sts_i.regime == REG_LOADING) && sts_i.k_ne_el) begin
          op_o = OP_UO_MUL;
        end
      end
      ST_COH_W:    if (sts_i.div_done) op_o = OP_COH_EDGE;
      ST_UO_MW:    if (sts_i.mul_done) op_o = OP_UO_DIV;
      ST_UO_DW:    if (sts_i.div_done) op_o = OP_UO_SET;
      ST_F_START:  op_o = OP_F_MUL;
      ST_F_W:      if (sts_i.mul_done) op_o = OP_F_SET;
      ST_E_START:  op_o = OP_E_MUL;
      ST_E_MW:     if (sts_i.mul_done) op_o = OP_E_DIV;
      ST_E_DW:     if (sts_i.div_done) op_o = OP_E_SET;
      ST_OUT:      if (out_free_i) op_o = OP_PUSH;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/elastoplastic_contact_normal_force_core.sv
// ----------------------------------------------------------------------------
// elastoplastic_contact_normal_force_core
// Duration: shortest for a separated contact or an update that needs neither
//   the unloading stiffness nor a force, longest for post-yield loading with
//   force applied.
// Throughput: one update at a time; the shift-add multiplier and the
//   restoring divider, run up to seven times in sequence, set it.
// Reset: asynchronous; configuration registers return to their defaults and
//   the contact state (largest and unloaded overlap) clears to zero.
// ----------------------------------------------------------------------------
`include "elastoplastic_contact_normal_force_core_macros.svh"

module elastoplastic_contact_normal_force_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ecnf_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ecnf_pkg::out_item_t      out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ecnf_pkg::CIW-1:0] cfg_index_i,
  input  logic [ecnf_pkg::VW-1:0]  cfg_data_i
);
  import ecnf_pkg::*;

  dp_op_e    op;
  dp_sts_t   sts;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  ecnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .sts_i      (sts),
    .op_o       (op)
  );

  ecnf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_data_i),
    .sts_o      (sts),
    .res_o      (res)
  );

  // Output register: hold the result until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_PUSH) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ECNF_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")
  `ECNF_ASSERT_IMP(a_separated_idle, out_valid_o && (out_data_o.regime == REG_SEPARATED), (out_data_o.stiffness == UW'(1)) && (out_data_o.force_increment == '0) && (out_data_o.energy_increment == '0), "separated result carries force")
  `ECNF_ASSERT_IMP(a_energy_needs_force, out_valid_o && (out_data_o.force_increment == '0), out_data_o.energy_increment == '0, "energy without force")

endmodule
